[sv/fcst_pkg.sv]
// Shared types, constants and step helpers for the filter cutoff step tuner.
// Used by fcst_csr, fcst_step and filter_cutoff_step_tuner; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcst_pkg;

   // Field widths
   localparam int CUT_W   = 10;
   localparam int STEP_W  = 8;
   localparam int PEAK_W  = 16;
   localparam int NOISE_W = 32;
   localparam int IDX_W   = 3;

   // Resonance test: peak above 30 Hz in Q12.4, cutoff above 0.7 * peak
   localparam logic [PEAK_W-1:0] RES_MIN_Q4 = 16'd480;
   localparam int PROD_W   = 19;
   localparam int PEAK_NUM = 7;
   localparam int CUT_DEN  = 160;

   // Noise ratio test: goal must exceed 0.1 in Q16.16, bands at 0.8 and 1.2
   localparam logic [NOISE_W-1:0] GOAL_MIN_Q16 = 32'd6553;
   localparam int RATIO_W   = NOISE_W + 3;
   localparam int NOW_MUL   = 5;
   localparam int LOW_MUL   = 4;
   localparam int HIGH_MUL  = 6;

   // Register reset values
   localparam logic [STEP_W-1:0] RST_STEP       = 8'd10;
   localparam logic [CUT_W-1:0]  RST_DTERM1_MIN = 10'd37;
   localparam logic [CUT_W-1:0]  RST_DTERM1_MAX = 10'd112;
   localparam logic [CUT_W-1:0]  RST_DTERM2_MIN = 10'd75;
   localparam logic [CUT_W-1:0]  RST_DTERM2_MAX = 10'd225;
   localparam logic [CUT_W-1:0]  RST_GYRO1_MIN  = 10'd125;
   localparam logic [CUT_W-1:0]  RST_GYRO1_MAX  = 10'd375;
   localparam logic [CUT_W-1:0]  RST_GYRO2_MAX  = 10'd750;

   typedef enum logic [IDX_W-1:0] {
      CSR_STEP       = 3'd0,
      CSR_DTERM1_MIN = 3'd1,
      CSR_DTERM1_MAX = 3'd2,
      CSR_DTERM2_MIN = 3'd3,
      CSR_DTERM2_MAX = 3'd4,
      CSR_GYRO1_MIN  = 3'd5,
      CSR_GYRO1_MAX  = 3'd6,
      CSR_GYRO2_MAX  = 3'd7
   } fcst_csr_idx_type;

   typedef enum logic [2:0] {
      RSN_RESONANCE  = 3'd0,
      RSN_NOISE_LOW  = 3'd1,
      RSN_NOISE_HIGH = 3'd2,
      RSN_AT_LIMIT   = 3'd3,
      RSN_NOISE_OK   = 3'd4
   } fcst_reason_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [CUT_W-1:0]  dterm1_min;
      logic [CUT_W-1:0]  dterm1_max;
      logic [CUT_W-1:0]  dterm2_min;
      logic [CUT_W-1:0]  dterm2_max;
      logic [CUT_W-1:0]  gyro1_min;
      logic [CUT_W-1:0]  gyro1_max;
      logic [CUT_W-1:0]  gyro2_max;
   } fcst_cfg_type;

   typedef struct packed {
      logic               resonance_seen;
      logic [PEAK_W-1:0]  peak_freq_q4;
      logic [NOISE_W-1:0] noise_now_q16;
      logic [NOISE_W-1:0] noise_goal_q16;
      logic [CUT_W-1:0]   gyro_first_static_hz;
      logic [CUT_W-1:0]   gyro_first_dyn_hz;
      logic [CUT_W-1:0]   gyro_second_hz;
      logic [CUT_W-1:0]   dterm_first_static_hz;
      logic [CUT_W-1:0]   dterm_first_dyn_hz;
      logic [CUT_W-1:0]   dterm_second_hz;
   } fcst_req_type;

   typedef struct packed {
      logic              any_changed;
      fcst_reason_type   reason_code;
      logic [CUT_W-1:0]  gyro_first_static_hz;
      logic [CUT_W-1:0]  gyro_first_dyn_hz;
      logic [CUT_W-1:0]  gyro_second_hz;
      logic [CUT_W-1:0]  dterm_first_static_hz;
      logic [CUT_W-1:0]  dterm_first_dyn_hz;
      logic [CUT_W-1:0]  dterm_second_hz;
   } fcst_rsp_type;

   // Lower a cutoff by one step without wrapping, then clamp to the minimum
   function automatic logic [CUT_W-1:0] step_down(
      input logic [CUT_W-1:0]  cut,
      input logic [STEP_W-1:0] step,
      input logic [CUT_W-1:0]  lo
   );
      logic [CUT_W-1:0] step_ext;
      logic [CUT_W-1:0] v;
      step_ext = {{(CUT_W-STEP_W){1'b0}}, step};
      v = (cut > step_ext) ? (cut - step_ext) : '0;
      return (v > lo) ? v : lo;
   endfunction

   // Raise a cutoff by one step, then clamp to the maximum
   function automatic logic [CUT_W-1:0] step_up(
      input logic [CUT_W-1:0]  cut,
      input logic [STEP_W-1:0] step,
      input logic [CUT_W-1:0]  hi
   );
      logic [CUT_W:0] v;
      v = {1'b0, cut} + {{(CUT_W+1-STEP_W){1'b0}}, step};
      return (v < {1'b0, hi}) ? v[CUT_W-1:0] : hi;
   endfunction

   // Cutoff sits above 0.7 times the peak (both sides scaled to integers)
   function automatic logic above_peak(
      input logic [CUT_W-1:0]  cut,
      input logic [PROD_W-1:0] peak7
   );
      logic [PROD_W-1:0] cut160;
      cut160 = PROD_W'(cut) * PROD_W'(CUT_DEN);
      return cut160 > peak7;
   endfunction

endpackage

`default_nettype wire

[sv/filter_cutoff_step_tuner.sv]
// Top level of the filter cutoff step tuner: request register, decision
// logic, result register. Depends on fcst_pkg, fcst_csr and fcst_step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock and returns one result per request, in order,
// passing through the request register, the step decision and then the result
// register. Throughput is one request per cycle for
// as long as the result side does not stall; req_stall follows rsp_stall in
// the same cycle only when both registers are full. Registers are written
// through csr_we/csr_index/csr_wdata and should change only while no request
// is in flight.
module filter_cutoff_step_tuner
   import fcst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_we,
   input  wire logic [IDX_W-1:0]   csr_index,
   input  wire logic [CUT_W-1:0]   csr_wdata,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_resonance_seen,
   input  wire logic [PEAK_W-1:0]  req_peak_freq_q4,
   input  wire logic [NOISE_W-1:0] req_noise_now_q16,
   input  wire logic [NOISE_W-1:0] req_noise_goal_q16,
   input  wire logic [CUT_W-1:0]   req_gyro_first_static_hz,
   input  wire logic [CUT_W-1:0]   req_gyro_first_dyn_hz,
   input  wire logic [CUT_W-1:0]   req_gyro_second_hz,
   input  wire logic [CUT_W-1:0]   req_dterm_first_static_hz,
   input  wire logic [CUT_W-1:0]   req_dterm_first_dyn_hz,
   input  wire logic [CUT_W-1:0]   req_dterm_second_hz,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_any_changed,
   output logic [2:0]              rsp_reason_code,
   output logic [CUT_W-1:0]        rsp_new_gyro_first_static_hz,
   output logic [CUT_W-1:0]        rsp_new_gyro_first_dyn_hz,
   output logic [CUT_W-1:0]        rsp_new_gyro_second_hz,
   output logic [CUT_W-1:0]        rsp_new_dterm_first_static_hz,
   output logic [CUT_W-1:0]        rsp_new_dterm_first_dyn_hz,
   output logic [CUT_W-1:0]        rsp_new_dterm_second_hz
);

   fcst_cfg_type cfg;
   fcst_req_type req_in;
   fcst_req_type req_ff;
   logic         req_valid_ff;
   logic         req_valid_in;
   fcst_rsp_type rsp_in;
   fcst_rsp_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         adv_req;
   logic         adv_rsp;

   fcst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fcst_step u_step (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_in)
   );

   // Gather the request fields
   always_comb begin
      req_in.resonance_seen        = req_resonance_seen;
      req_in.peak_freq_q4          = req_peak_freq_q4;
      req_in.noise_now_q16         = req_noise_now_q16;
      req_in.noise_goal_q16        = req_noise_goal_q16;
      req_in.gyro_first_static_hz  = req_gyro_first_static_hz;
      req_in.gyro_first_dyn_hz     = req_gyro_first_dyn_hz;
      req_in.gyro_second_hz        = req_gyro_second_hz;
      req_in.dterm_first_static_hz = req_dterm_first_static_hz;
      req_in.dterm_first_dyn_hz    = req_dterm_first_dyn_hz;
      req_in.dterm_second_hz       = req_dterm_second_hz;
   end

   // Advance each stage when the one after it can take its contents
   assign adv_rsp      = !rsp_valid_ff || !rsp_stall;
   assign adv_req      = !req_valid_ff || adv_rsp;
   assign req_stall    = !adv_req;
   assign req_valid_in = adv_req ? req_valid : req_valid_ff;
   assign rsp_valid_in = adv_rsp ? req_valid_ff : rsp_valid_ff;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payloads: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (adv_req && req_valid) begin
         req_ff <= req_in;
      end
      if (adv_rsp && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the result ports
   assign rsp_valid                     = rsp_valid_ff;
   assign rsp_any_changed               = rsp_ff.any_changed;
   assign rsp_reason_code               = rsp_ff.reason_code;
   assign rsp_new_gyro_first_static_hz  = rsp_ff.gyro_first_static_hz;
   assign rsp_new_gyro_first_dyn_hz     = rsp_ff.gyro_first_dyn_hz;
   assign rsp_new_gyro_second_hz        = rsp_ff.gyro_second_hz;
   assign rsp_new_dterm_first_static_hz = rsp_ff.dterm_first_static_hz;
   assign rsp_new_dterm_first_dyn_hz    = rsp_ff.dterm_first_dyn_hz;
   assign rsp_new_dterm_second_hz       = rsp_ff.dterm_second_hz;

   // Both stages empty right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !req_valid_ff))
      else $error("pipeline not empty after reset");

   // A step is only reported with a resonance or noise reason
   a_changed_reason : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.any_changed) |->
         (rsp_ff.reason_code == RSN_RESONANCE || rsp_ff.reason_code == RSN_NOISE_LOW
          || rsp_ff.reason_code == RSN_NOISE_HIGH))
      else $error("step reported with wrong reason");

   // No step means at limit or noise ok
   a_idle_reason : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.any_changed) |->
         (rsp_ff.reason_code == RSN_AT_LIMIT || rsp_ff.reason_code == RSN_NOISE_OK))
      else $error("no step but step reason");

   // Full pipeline with a stalled result must back-pressure the request side
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request accepted into full pipeline");

   // A stalled result register keeps its request queued behind it
   a_hold_queued : assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && rsp_stall) |=> req_valid_ff)
      else $error("queued request lost");

endmodule

`default_nettype wire

[sv/fcst_csr.sv]
// Configuration registers of the filter cutoff step tuner.
// Depends on fcst_pkg for the register index codes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module fcst_csr
   import fcst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [IDX_W-1:0]    csr_index,
   input  wire logic [CUT_W-1:0]    csr_wdata,
   output fcst_cfg_type             cfg
);

   fcst_cfg_type cfg_ff;
   fcst_cfg_type cfg_in;

   // Decode the write onto one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (fcst_csr_idx_type'(csr_index))
            CSR_STEP:       cfg_in.step       = csr_wdata[STEP_W-1:0];
            CSR_DTERM1_MIN: cfg_in.dterm1_min = csr_wdata;
            CSR_DTERM1_MAX: cfg_in.dterm1_max = csr_wdata;
            CSR_DTERM2_MIN: cfg_in.dterm2_min = csr_wdata;
            CSR_DTERM2_MAX: cfg_in.dterm2_max = csr_wdata;
            CSR_GYRO1_MIN:  cfg_in.gyro1_min  = csr_wdata;
            CSR_GYRO1_MAX:  cfg_in.gyro1_max  = csr_wdata;
            CSR_GYRO2_MAX:  cfg_in.gyro2_max  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step       <= RST_STEP;
         cfg_ff.dterm1_min <= RST_DTERM1_MIN;
         cfg_ff.dterm1_max <= RST_DTERM1_MAX;
         cfg_ff.dterm2_min <= RST_DTERM2_MIN;
         cfg_ff.dterm2_max <= RST_DTERM2_MAX;
         cfg_ff.gyro1_min  <= RST_GYRO1_MIN;
         cfg_ff.gyro1_max  <= RST_GYRO1_MAX;
         cfg_ff.gyro2_max  <= RST_GYRO2_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/fcst_step.sv]
// Combinational decision of the filter cutoff step tuner: picks at most one
// cutoff to step and the reason code. Depends on fcst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcst_step
   import fcst_pkg::*;
(
   input  wire fcst_req_type req,
   input  wire fcst_cfg_type cfg,
   output fcst_rsp_type      rsp
);

   logic              gdyn;
   logic              ddyn;
   logic [CUT_W-1:0]  g1;
   logic [CUT_W-1:0]  d1;
   logic [CUT_W-1:0]  g1_new;
   logic [CUT_W-1:0]  d1_new;
   logic [CUT_W-1:0]  d2_new;
   logic [CUT_W-1:0]  g2_new;
   logic [PROD_W-1:0] peak7;
   logic              res_active;
   logic              res_d1;
   logic              res_d2;
   logic              res_g1;
   logic [RATIO_W-1:0] now5;
   logic [RATIO_W-1:0] goal4;
   logic [RATIO_W-1:0] goal6;
   logic              goal_big;
   logic              noise_low;
   logic              noise_high;
   logic              changed;
   fcst_reason_type   reason;

   // Working first-stage cutoffs: dynamic when static is off and dynamic set
   assign gdyn = (req.gyro_first_static_hz == '0) && (req.gyro_first_dyn_hz != '0);
   assign ddyn = (req.dterm_first_static_hz == '0) && (req.dterm_first_dyn_hz != '0);
   assign g1   = gdyn ? req.gyro_first_dyn_hz : req.gyro_first_static_hz;
   assign d1   = ddyn ? req.dterm_first_dyn_hz : req.dterm_first_static_hz;

   // Resonance candidates above 0.7 times the peak
   assign peak7      = PROD_W'(req.peak_freq_q4) * PROD_W'(PEAK_NUM);
   assign res_active = req.resonance_seen && (req.peak_freq_q4 > RES_MIN_Q4);
   assign res_d1     = (d1 > cfg.dterm1_min) && above_peak(d1, peak7);
   assign res_d2     = (req.dterm_second_hz > cfg.dterm2_min)
                       && (req.dterm_second_hz != '0)
                       && above_peak(req.dterm_second_hz, peak7);
   assign res_g1     = (g1 != '0) && (g1 > cfg.gyro1_min) && above_peak(g1, peak7);

   // Noise ratio bands by cross-multiplication
   assign now5       = RATIO_W'(req.noise_now_q16) * RATIO_W'(NOW_MUL);
   assign goal4      = RATIO_W'(req.noise_goal_q16) * RATIO_W'(LOW_MUL);
   assign goal6      = RATIO_W'(req.noise_goal_q16) * RATIO_W'(HIGH_MUL);
   assign goal_big   = req.noise_goal_q16 > GOAL_MIN_Q16;
   assign noise_low  = goal_big && (now5 < goal4);
   assign noise_high = goal_big && (now5 > goal6);

   // Pick one cutoff in priority order
   always_comb begin
      d1_new  = d1;
      d2_new  = req.dterm_second_hz;
      g1_new  = g1;
      g2_new  = req.gyro_second_hz;
      changed = 1'b0;
      reason  = RSN_NOISE_OK;
      if (res_active && (res_d1 || res_d2 || res_g1)) begin
         changed = 1'b1;
         reason  = RSN_RESONANCE;
         if (res_d1) begin
            d1_new = step_down(d1, cfg.step, cfg.dterm1_min);
         end else if (res_d2) begin
            d2_new = step_down(req.dterm_second_hz, cfg.step, cfg.dterm2_min);
         end else begin
            g1_new = step_down(g1, cfg.step, cfg.gyro1_min);
         end
      end else if (noise_low) begin
         changed = 1'b1;
         reason  = RSN_NOISE_LOW;
         if ((d1 != '0) && (d1 < cfg.dterm1_max)) begin
            d1_new = step_up(d1, cfg.step, cfg.dterm1_max);
         end else if ((req.dterm_second_hz < cfg.dterm2_max)
                      && (req.dterm_second_hz != '0)) begin
            d2_new = step_up(req.dterm_second_hz, cfg.step, cfg.dterm2_max);
         end else if ((g1 != '0) && (g1 < cfg.gyro1_max)) begin
            g1_new = step_up(g1, cfg.step, cfg.gyro1_max);
         end else if ((req.gyro_second_hz != '0)
                      && (req.gyro_second_hz < cfg.gyro2_max)) begin
            g2_new = step_up(req.gyro_second_hz, cfg.step, cfg.gyro2_max);
         end else begin
            changed = 1'b0;
            reason  = RSN_AT_LIMIT;
         end
      end else if (noise_high) begin
         changed = 1'b1;
         reason  = RSN_NOISE_HIGH;
         if (d1 > cfg.dterm1_min) begin
            d1_new = step_down(d1, cfg.step, cfg.dterm1_min);
         end else if ((req.dterm_second_hz > cfg.dterm2_min)
                      && (req.dterm_second_hz != '0)) begin
            d2_new = step_down(req.dterm_second_hz, cfg.step, cfg.dterm2_min);
         end else if ((g1 != '0) && (g1 > cfg.gyro1_min)) begin
            g1_new = step_down(g1, cfg.step, cfg.gyro1_min);
         end else begin
            changed = 1'b0;
            reason  = RSN_AT_LIMIT;
         end
      end
   end

   // Write first stages back to whichever field is working
   always_comb begin
      rsp.any_changed           = changed;
      rsp.reason_code           = reason;
      rsp.gyro_first_static_hz  = gdyn ? req.gyro_first_static_hz : g1_new;
      rsp.gyro_first_dyn_hz     = gdyn ? g1_new : req.gyro_first_dyn_hz;
      rsp.gyro_second_hz        = g2_new;
      rsp.dterm_first_static_hz = ddyn ? req.dterm_first_static_hz : d1_new;
      rsp.dterm_first_dyn_hz    = ddyn ? d1_new : req.dterm_first_dyn_hz;
      rsp.dterm_second_hz       = d2_new;
   end

endmodule

`default_nettype wire
